// ===== hdl/lmc_pkg.sv =====
// lmc_pkg: widths, constants, codes and shared types of the level to motor command mapper
// used by every file under hdl; depends on nothing
package lmc_pkg;

  localparam int LEVEL_BITS = 16;
  localparam int CMD_BITS   = 16;
  localparam int GAIN_FRAC  = 16;
  localparam int GAIN_BITS  = GAIN_FRAC + 1;
  localparam int MODE_BITS  = 3;
  localparam int DB_BITS    = 8;
  localparam int IDX_BITS   = 2;
  localparam int CFG_BITS   = GAIN_BITS;
  localparam int KS_BITS    = 2;
  localparam int SLOW_SHIFT = 2;

  // datapath widths
  localparam int NUM_BITS  = LEVEL_BITS + DB_BITS;
  localparam int MUL_BITS  = LEVEL_BITS + GAIN_BITS;
  localparam int DEN_BITS  = LEVEL_BITS + GAIN_BITS + 1;
  localparam int DVD_BITS  = LEVEL_BITS + GAIN_BITS + CMD_BITS;
  localparam int QW        = (CMD_BITS > GAIN_BITS) ? CMD_BITS : GAIN_BITS;
  localparam int CQG_BITS  = 2 * GAIN_BITS;
  localparam int PROD_BITS = CQG_BITS + CMD_BITS - 1;

  // queue between front and back, depth a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR   = $clog2(QDEPTH);
  localparam int QCNT   = $clog2(QDEPTH + 1);

  localparam logic [LEVEL_BITS-1:0] LMAX     = '1;
  localparam logic [CMD_BITS-2:0]   CMAX     = '1;
  localparam logic [GAIN_BITS-1:0]  GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;
  localparam logic [DB_BITS-1:0]    DB_FULL  = '1;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_MODE     = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_DEADBAND = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_REVERSE  = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_GAIN     = 2'd3;

  // modes
  localparam logic [MODE_BITS-1:0] MODE_FULL_UNI    = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_FULL_UNI16  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_HALF_UNI    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_QUARTER_UNI = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_FULL_BI     = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_SLOW_BI     = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_FULL_BI16   = 3'd6;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [DB_BITS-1:0]   deadband;
    logic                 reverse;
    logic [GAIN_BITS-1:0] gain;
  } cfg_t;

  // classified item, as it waits in the queue
  typedef struct packed {
    logic                 bi;
    logic                 slow;
    logic                 neg;
    logic                 dead;
    logic [KS_BITS-1:0]   ks;
    logic [NUM_BITS-1:0]  x;
    logic [DB_BITS-1:0]   dbm;
    logic [GAIN_BITS-1:0] g;
  } item_t;

  // what rides along with the divider
  typedef struct packed {
    logic                 bi;
    logic                 slow;
    logic                 neg;
    logic                 dead;
    logic [GAIN_BITS-1:0] g;
  } meta_t;

endpackage

// ===== hdl/lmc_front.sv =====
// lmc_front: accepts a level and classifies it under the current mode
// produces the queue entry; depends on lmc_pkg
module lmc_front import lmc_pkg::*; (
  input  logic                  start,
  input  logic [LEVEL_BITS-1:0] level,
  input  cfg_t                  cfg,
  input  logic                  full,
  output logic                  busy,
  output logic                  push,
  output item_t                 item
);

  logic [LEVEL_BITS:0]   twice;
  logic [LEVEL_BITS:0]   dist_w;
  logic [LEVEL_BITS-1:0] offset;
  logic [LEVEL_BITS-1:0] du;
  logic                  below;
  logic [NUM_BITS-1:0]   d255;
  logic [DB_BITS:0]      db2;
  logic [NUM_BITS:0]     lim;
  logic [NUM_BITS-1:0]   num;
  logic [GAIN_BITS-1:0]  g;
  logic                  bi;
  logic                  slow;
  logic [KS_BITS-1:0]    ks;

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    bi   = 1'b0;
    slow = 1'b0;
    ks   = 2'd0;
    unique case (cfg.mode)
      MODE_FULL_UNI, MODE_FULL_UNI16: ks = 2'd0;
      MODE_HALF_UNI:                  ks = 2'd1;
      MODE_QUARTER_UNI:               ks = 2'd2;
      MODE_FULL_BI, MODE_FULL_BI16:   bi = 1'b1;
      MODE_SLOW_BI: begin
        bi   = 1'b1;
        slow = 1'b1;
      end
      default:                        ks = 2'd0;
    endcase
  end

  always_comb begin
    twice  = {level, 1'b0};
    below  = twice < {1'b0, LMAX};
    dist_w = below ? ({1'b0, LMAX} - twice) : (twice - {1'b0, LMAX});
    offset = dist_w[LEVEL_BITS-1:0];
    // offset * 255 and the dead zone edge 2 * deadband * full scale
    d255   = {offset, {DB_BITS{1'b0}}} - NUM_BITS'(offset);
    db2    = {cfg.deadband, 1'b0};
    lim    = {db2, {LEVEL_BITS{1'b0}}} - (NUM_BITS + 1)'(db2);
    num    = d255 - lim[NUM_BITS-1:0];
    du     = cfg.reverse ? (LMAX - level) : level;
    g      = (cfg.gain > GAIN_ONE) ? GAIN_ONE : cfg.gain;
  end

  always_comb begin
    item.bi   = bi;
    item.slow = slow;
    item.neg  = below ^ cfg.reverse;
    item.dead = cfg.deadband[DB_BITS-1] || ({1'b0, d255} <= lim);
    item.ks   = ks;
    item.x    = bi ? num : NUM_BITS'(du);
    item.dbm  = DB_FULL - db2[DB_BITS-1:0];
    item.g    = g;
  end

endmodule

// ===== hdl/lmc_queue.sv =====
// lmc_queue: short register queue between the front and the back
// holds classified items; depends on lmc_pkg
module lmc_queue import lmc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  item_t             mem [QDEPTH];
  logic [QPTR-1:0]   wr_ptr;
  logic [QPTR-1:0]   rd_ptr;
  logic [QCNT-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == QCNT'(QDEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // pointers wrap naturally at a power-of-two depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // the back drains every cycle, so the queue never fills
  a_never_full: assert property (@(posedge clk) disable iff (rst) !full)
    else $error("queue filled although the back drains every cycle");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on a transfer out");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not rise on a transfer in");

endmodule

// ===== hdl/lmc_div.sv =====
// lmc_div: pipelined restoring divider, one quotient bit per stage
// carries a meta_t alongside each quotient; depends on lmc_pkg
module lmc_div import lmc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [DVD_BITS-1:0] dvd,
  input  logic [DEN_BITS-1:0] den,
  input  meta_t               in_meta,
  output logic                out_valid,
  output logic [QW-1:0]       quo,
  output meta_t               out_meta
);

  logic                vld [QW+1];
  logic [DEN_BITS:0]   rem [QW+1];
  logic [QW-1:0]       lo  [QW+1];
  logic [DEN_BITS-1:0] dv  [QW+1];
  meta_t               md  [QW+1];

  // the upper part of the dividend is below the divisor whenever the quotient fits
  assign vld[0] = in_valid;
  assign rem[0] = (DEN_BITS + 1)'(dvd >> QW);
  assign lo[0]  = dvd[QW-1:0];
  assign dv[0]  = den;
  assign md[0]  = in_meta;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DEN_BITS:0] t;
    logic              ge;

    always_comb begin
      t  = {rem[j][DEN_BITS-1:0], lo[j][QW-1]};
      ge = t >= {1'b0, dv[j]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      rem[j+1] <= ge ? (t - {1'b0, dv[j]}) : t;
      lo[j+1]  <= {lo[j][QW-2:0], ge};
      dv[j+1]  <= dv[j];
      md[j+1]  <= md[j];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = lo[QW];
  assign out_meta  = md[QW];

endmodule

// ===== hdl/lmc_back.sv =====
// lmc_back: carries out the mapping of a classified item, rescale, divide, scale, clamp
// instantiates lmc_div; depends on lmc_pkg
module lmc_back import lmc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  item_t               in_item,
  output logic                done,
  output logic [CMD_BITS-1:0] command,
  output logic                two_way
);

  // stage 0: one shared multiplier, den for bi, level times gain for uni
  logic [GAIN_BITS-1:0]  ma;
  logic [LEVEL_BITS-1:0] mb;
  logic [MUL_BITS-1:0]   mprod;

  logic                  b0_vld;
  item_t                 b0_it;
  logic [MUL_BITS-1:0]   b0_prod;

  assign ma    = in_item.bi ? GAIN_BITS'(in_item.dbm) : in_item.g;
  assign mb    = in_item.bi ? LMAX : in_item.x[LEVEL_BITS-1:0];
  assign mprod = ma * mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_vld <= 1'b0;
    end else begin
      b0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    b0_it   <= in_item;
    b0_prod <= mprod;
  end

  // stage 1: dividend and divisor, rounding half folded into the dividend
  logic [DVD_BITS-2:0]   uprod;
  logic [DEN_BITS-1:0]   uden;
  logic [DVD_BITS-1:0]   dvd_c;
  logic [DEN_BITS-1:0]   den_c;
  meta_t                 meta_c;

  logic                  b1_vld;
  logic [DVD_BITS-1:0]   b1_dvd;
  logic [DEN_BITS-1:0]   b1_den;
  meta_t                 b1_meta;

  assign uprod = b0_prod * CMAX;
  assign uden  = DEN_BITS'(LMAX) << (GAIN_FRAC + int'(b0_it.ks));

  always_comb begin
    if (b0_it.bi) begin
      dvd_c = {{(DVD_BITS - NUM_BITS - GAIN_FRAC){1'b0}}, b0_it.x, {GAIN_FRAC{1'b0}}}
              + DVD_BITS'(b0_prod >> 1);
      den_c = DEN_BITS'(b0_prod);
    end else begin
      dvd_c = {1'b0, uprod} + DVD_BITS'(uden >> 1);
      den_c = uden;
    end
    meta_c.bi   = b0_it.bi;
    meta_c.slow = b0_it.slow;
    meta_c.neg  = b0_it.neg;
    meta_c.dead = b0_it.dead;
    meta_c.g    = b0_it.g;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
    end else begin
      b1_vld <= b0_vld;
    end
  end

  always_ff @(posedge clk) begin
    b1_dvd  <= dvd_c;
    b1_den  <= den_c;
    b1_meta <= meta_c;
  end

  logic                  dq_vld;
  logic [QW-1:0]         dq;
  meta_t                 dq_meta;

  lmc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b1_vld),
    .dvd       (b1_dvd),
    .den       (b1_den),
    .in_meta   (b1_meta),
    .out_valid (dq_vld),
    .quo       (dq),
    .out_meta  (dq_meta)
  );

  // post 1: clamp quotient, bi times gain
  logic [GAIN_BITS-1:0]  cq;
  logic [CMD_BITS-2:0]   umag;
  logic [CQG_BITS-1:0]   cqg;

  logic                  p1_vld;
  logic [CQG_BITS-1:0]   p1_val;
  meta_t                 p1_meta;

  assign cq   = (dq > QW'(GAIN_ONE)) ? GAIN_ONE : dq[GAIN_BITS-1:0];
  assign umag = (dq > QW'(CMAX)) ? CMAX : dq[CMD_BITS-2:0];
  assign cqg  = cq * dq_meta.g;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= dq_vld;
    end
  end

  always_ff @(posedge clk) begin
    p1_val  <= dq_meta.bi ? cqg : CQG_BITS'(umag);
    p1_meta <= dq_meta;
  end

  // post 2: bi times full-scale command
  logic [PROD_BITS-1:0]  scaled;

  logic                  p2_vld;
  logic [PROD_BITS-1:0]  p2_val;
  meta_t                 p2_meta;

  assign scaled = p1_val * CMAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    p2_val  <= p1_meta.bi ? scaled : PROD_BITS'(p1_val);
    p2_meta <= p1_meta;
  end

  // bi output: round, shift out the two Q.16 fractions (plus span if slow), clamp, sign
  int unsigned           sh;
  logic [PROD_BITS:0]    rsum;
  logic [PROD_BITS:0]    rsh;
  logic [CMD_BITS-2:0]   bmag;
  logic [CMD_BITS-1:0]   bcmd;
  logic [CMD_BITS-1:0]   cmd_c;

  always_comb begin
    sh    = 2 * GAIN_FRAC + (p2_meta.slow ? SLOW_SHIFT : 0);
    rsum  = {1'b0, p2_val} + ((PROD_BITS + 1)'(1) << (sh - 1));
    rsh   = rsum >> sh;
    bmag  = (rsh > (PROD_BITS + 1)'(CMAX)) ? CMAX : rsh[CMD_BITS-2:0];
    if (p2_meta.dead) begin
      bmag = '0;
    end
    bcmd  = p2_meta.neg ? (CMD_BITS'(0) - {1'b0, bmag}) : {1'b0, bmag};
    cmd_c = p2_meta.bi ? bcmd : {1'b0, p2_val[CMD_BITS-2:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    command <= cmd_c;
    two_way <= p2_meta.bi;
  end

endmodule

// ===== hdl/level_to_motor_command_map.sv =====
// level_to_motor_command_map: top level, configuration registers, front, queue and back
// instantiates lmc_front, lmc_queue and lmc_back; depends on lmc_pkg
//
// Maps one control level to a signed motor command under the configured mode. A level is
// taken at every clock edge where start is high and busy is low, one per cycle sustained;
// each command appears on command/two_way for exactly one cycle with done high, in order,
// after passing the queue, stage 0, stage 1, the divider (one quotient bit per pipeline
// stage), post 1, post 2 and the output register. The result side has no stall: capture
// command whenever done is high. busy reflects a full queue between front and back and
// stays low as long as the back drains, which it does every cycle. Registers are written
// through wr_en/wr_index/wr_data; the user must write them only while no level is in
// flight, which the block itself does not enforce.
module level_to_motor_command_map import lmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [LEVEL_BITS-1:0] level,
  input  logic                  wr_en,
  input  logic [IDX_BITS-1:0]   wr_index,
  input  logic [CFG_BITS-1:0]   wr_data,
  output logic                  done,
  output logic [CMD_BITS-1:0]   command,
  output logic                  two_way
);

  localparam int LATENCY = QW + 6;

  cfg_t  cfg;
  logic  push;
  logic  full;
  logic  empty;
  item_t fr_item;
  item_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode     <= MODE_FULL_UNI;
      cfg.deadband <= '0;
      cfg.reverse  <= 1'b0;
      cfg.gain     <= GAIN_ONE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE:     cfg.mode     <= wr_data[MODE_BITS-1:0];
        REG_DEADBAND: cfg.deadband <= wr_data[DB_BITS-1:0];
        REG_REVERSE:  cfg.reverse  <= wr_data[0];
        REG_GAIN:     cfg.gain     <= wr_data[GAIN_BITS-1:0];
        default:      cfg.mode     <= cfg.mode;
      endcase
    end
  end

  lmc_front u_front (
    .start (start),
    .level (level),
    .cfg   (cfg),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .item  (fr_item)
  );

  lmc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (fr_item),
    .pop     (!empty),
    .head    (q_head),
    .empty   (empty),
    .full    (full)
  );

  lmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (!empty),
    .in_item  (q_head),
    .done     (done),
    .command  (command),
    .two_way  (two_way)
  );

  // every transfer in comes out after the fixed pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing at the expected cycle after a transfer in");

endmodule

// ===== bench/lmc_checker.sv =====
`timescale 1ns / 1ps
// lmc_checker: predicts the motor command for every level transfer and compares it with each done
// tracks register writes seen on the write port; depends on lmc_pkg
module lmc_checker import lmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [LEVEL_BITS-1:0] level,
  input  logic                  wr_en,
  input  logic [IDX_BITS-1:0]   wr_index,
  input  logic [CFG_BITS-1:0]   wr_data,
  input  logic                  done,
  input  logic [CMD_BITS-1:0]   command,
  input  logic                  two_way,
  output int                    mismatch_count,
  output int                    commands_checked,
  output int                    commands_pending
);

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [CMD_BITS-1:0]   command;
    logic                  two_way;
  } motor_cmd_t;

  localparam int PRINT_CAP = 100;

  logic [MODE_BITS-1:0] mode_q;
  logic [DB_BITS-1:0]   deadband_q;
  logic                 reverse_q;
  logic [GAIN_BITS-1:0] gain_q;
  motor_cmd_t           expected_cmds[$];

  function automatic motor_cmd_t expected_command(input logic [LEVEL_BITS-1:0] lvl);
    longint unsigned lmax, cmax, lv, db, g, twice, offset, dead_edge;
    longint unsigned num, den, cq, mag, du, divisor;
    int unsigned sh;
    logic neg;
    motor_cmd_t r;
    lmax = LMAX;
    cmax = CMAX;
    lv = lvl;
    db = deadband_q;
    // gain register above one saturates
    g = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
    r.level = lvl;
    r.two_way = (mode_q == MODE_FULL_BI) || (mode_q == MODE_SLOW_BI) ||
                (mode_q == MODE_FULL_BI16);
    neg = 1'b0;
    mag = 0;
    if (r.two_way) begin
      twice = lv << 1;
      neg = twice < lmax;
      offset = neg ? lmax - twice : twice - lmax;
      dead_edge = 2 * db * lmax;
      // wide deadband, or inside the dead zone, gives zero
      if (db < 128 && offset * 255 > dead_edge) begin
        num = offset * 255 - dead_edge;
        den = lmax * (255 - 2 * db);
        cq = ((num << GAIN_FRAC) + den / 2) / den;
        if (cq > GAIN_ONE) cq = GAIN_ONE;
        sh = (mode_q == MODE_SLOW_BI) ? 32 + SLOW_SHIFT : 32;
        mag = (cq * g * cmax + (64'd1 << (sh - 1))) >> sh;
      end
      if (reverse_q) neg = !neg;
    end else begin
      // unused mode falls through here as full unidirectional
      du = reverse_q ? lmax - lv : lv;
      divisor = lmax << GAIN_FRAC;
      if (mode_q == MODE_HALF_UNI) divisor = divisor * 2;
      else if (mode_q == MODE_QUARTER_UNI) divisor = divisor * 4;
      mag = (du * g * cmax + divisor / 2) / divisor;
    end
    if (mag > cmax) mag = cmax;
    r.command = neg ? CMD_BITS'(0 - mag) : CMD_BITS'(mag);
    return r;
  endfunction

  // quiet after the first hundred lines, still counting
  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    motor_cmd_t want;
    if (rst) begin
      mode_q = MODE_FULL_UNI;
      deadband_q = '0;
      reverse_q = 1'b0;
      gain_q = GAIN_ONE;
      expected_cmds.delete();
      mismatch_count = 0;
      commands_checked = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_MODE:     mode_q = wr_data[MODE_BITS-1:0];
          REG_DEADBAND: deadband_q = wr_data[DB_BITS-1:0];
          REG_REVERSE:  reverse_q = wr_data[0];
          REG_GAIN:     gain_q = wr_data[GAIN_BITS-1:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_cmds.push_back(expected_command(level));
      if (done) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("command %0d with no transfer pending", $signed(command)));
        end else begin
          want = expected_cmds.pop_front();
          commands_checked++;
          if (command !== want.command)
            report_mismatch($sformatf("level %0d: command %0d, expected %0d",
                                      want.level, $signed(command), $signed(want.command)));
          if (two_way !== want.two_way)
            report_mismatch($sformatf("level %0d: two_way %b, expected %b",
                                      want.level, two_way, want.two_way));
        end
      end
    end
    // registered so the stimulus side never sees a same-edge update
    commands_pending <= expected_cmds.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: drives level transfers and register writes into level_to_motor_command_map
// instantiates the DUT and lmc_checker, gives the verdict; depends on lmc_pkg
module tb_top;
  import lmc_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 3'd7;
  localparam int LATENCY          = QW + 6;
  localparam int RAND_PHASES      = 16;
  localparam int LEVELS_PER_PHASE = 95;
  localparam int CYCLE_LIMIT      = 100000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [LEVEL_BITS-1:0] level;
  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_index;
  logic [CFG_BITS-1:0]   wr_data;
  logic                  done;
  logic [CMD_BITS-1:0]   command;
  logic                  two_way;
  int                    mismatch_count;
  int                    commands_checked;
  int                    commands_pending;
  int                    levels_sent = 0;
  int                    settings_applied = 0;
  int                    cycle_count = 0;
  // the receiver cannot stall; the sender runs with no gaps in every other phase
  int                    idle_pct[4] = '{0, 78, 0, 36};

  level_to_motor_command_map DUT (.*);
  lmc_checker cmd_check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic push_level(input logic [LEVEL_BITS-1:0] lvl);
    start <= 1'b1;
    level <= lvl;
    do @(posedge clk); while (busy);
    levels_sent++;
  endtask

  // per-cycle idle chance of pct percent before the next transfer
  task automatic sender_gap(input int pct);
    int n;
    n = 0;
    while ($urandom_range(99) < pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      level <= LEVEL_BITS'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (commands_pending != 0);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [MODE_BITS-1:0] m, input logic [DB_BITS-1:0] db,
                                input logic rev, input logic [GAIN_BITS-1:0] g);
    logic [CFG_BITS-1:0] noise;
    drain();
    noise = CFG_BITS'($urandom);
    // upper data bits carry noise the block must drop
    write_reg(REG_MODE, {noise[CFG_BITS-1:MODE_BITS], m});
    write_reg(REG_DEADBAND, {noise[CFG_BITS-1:DB_BITS], db});
    write_reg(REG_REVERSE, {noise[CFG_BITS-1:1], rev});
    write_reg(REG_GAIN, g);
    wr_en <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d commands still pending",
             cycle_count, commands_pending);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [MODE_BITS-1:0] m;
    logic [DB_BITS-1:0]   db;
    logic                 rev;
    logic [GAIN_BITS-1:0] g;
    rst = 1'b1;
    start = 1'b0;
    level = '0;
    wr_en = 1'b0;
    wr_index = REG_MODE;
    wr_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // register values straight out of reset
    push_level(0);
    push_level(65535);
    push_level(32768);

    // level extremes and both sides of mid-scale
    apply_settings(MODE_FULL_BI, 8'd0, 1'b0, GAIN_ONE);
    push_level(0);
    push_level(32767);
    push_level(32768);
    push_level(65535);

    // just inside and just outside a one-step dead zone
    apply_settings(MODE_FULL_BI, 8'd1, 1'b0, GAIN_ONE);
    push_level(33024);
    push_level(33025);

    // widest live deadband, reversed, gain register above one
    apply_settings(MODE_SLOW_BI, 8'd127, 1'b1, '1);
    push_level(0);
    push_level(65535);
    push_level(40000);

    // wide deadband forces zero
    apply_settings(MODE_FULL_BI16, 8'd128, 1'b0, GAIN_ONE);
    push_level(0);
    push_level(65535);
    apply_settings(MODE_FULL_BI, DB_FULL, 1'b1, GAIN_ONE);
    push_level(65535);

    apply_settings(MODE_UNUSED, 8'd0, 1'b1, GAIN_ONE);
    push_level(0);
    push_level(65535);

    apply_settings(MODE_FULL_UNI16, 8'd0, 1'b0, '1);
    push_level(65535);
    push_level(1);
    apply_settings(MODE_HALF_UNI, 8'd0, 1'b0, 17'd32768);
    push_level(65535);
    push_level(1);
    apply_settings(MODE_QUARTER_UNI, 8'd0, 1'b1, '0);
    push_level(0);
    push_level(65535);
    apply_settings(MODE_QUARTER_UNI, 8'd0, 1'b0, GAIN_ONE);
    push_level(65535);

    for (int p = 0; p < RAND_PHASES; p++) begin
      m = MODE_BITS'($urandom);
      case ($urandom_range(9))
        0: db = '0;
        1: db = DB_FULL;
        2: db = 8'd127;
        3: db = DB_BITS'($urandom_range(128, 255));
        default: db = DB_BITS'($urandom_range(60));
      endcase
      rev = 1'($urandom);
      case ($urandom_range(7))
        0: g = '0;
        1: g = GAIN_ONE;
        2: g = '1;
        3: g = GAIN_BITS'($urandom_range(65537, 131071));
        default: g = GAIN_BITS'($urandom_range(65536));
      endcase
      apply_settings(m, db, rev, g);
      for (int i = 0; i < LEVELS_PER_PHASE; i++) begin
        sender_gap(idle_pct[p % 4]);
        case ($urandom_range(9))
          0: push_level($urandom_range(1) ? 65535 : 0);
          1: push_level(LEVEL_BITS'($urandom_range(32467, 33068)));
          default: push_level(LEVEL_BITS'($urandom));
        endcase
      end
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d levels under %0d register settings, %0d commands checked",
             levels_sent, settings_applied, commands_checked);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
